### design/tqra_pkg.sv
// Shared types, codes and helpers for the two-queue runway arbiter.
package tqra_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int TICK_WIDTH_DEF  = 32;

   localparam logic [15:0] LANDING_DURATION_RST = 16'd5;
   localparam logic [15:0] TAKEOFF_DURATION_RST = 16'd5;
   localparam logic [15:0] OVERDUE_LIMIT_RST    = 16'd120;

   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

   // register indexes on the csr port
   localparam logic [1:0] CSR_LANDING_DURATION = 2'd0;
   localparam logic [1:0] CSR_TAKEOFF_DURATION = 2'd1;
   localparam logic [1:0] CSR_OVERDUE_LIMIT    = 2'd2;

   // served_kind codes
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_LANDING = 2'd1;
   localparam logic [1:0] KIND_TAKEOFF = 2'd2;
   localparam logic [1:0] KIND_OVERDUE = 2'd3;

   typedef struct packed {
      logic takeoff_arrival;
      logic landing_arrival;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  served_kind;
      logic [31:0] served_wait;
      logic [6:0]  landing_queue_len;
      logic [6:0]  takeoff_queue_len;
      logic [1:0]  drop_flags;
      logic        server_busy;
      logic [31:0] landings_done;
      logic [31:0] takeoffs_done;
      logic [47:0] landing_wait_sum;
      logic [47:0] takeoff_wait_sum;
      logic [47:0] landing_len_sum;
      logic [47:0] takeoff_len_sum;
   } rsp_word_type;

   // per-tick control broadcast along the cell chain
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? MAX48 : s[47:0];
   endfunction

   function automatic logic [31:0] sat_inc32(input logic [31:0] a);
      return (a == MAX32) ? MAX32 : a + 32'd1;
   endfunction

endpackage

### design/two_queue_runway_arbiter_with_aging.sv
// Top level: runway arbiter with landing and takeoff queues, aging and statistics.
//
// Usage: each word on the req_ channel is one tick carrying two arrival flags.
// Arrivals are stamped with the tick count and queued (landing and takeoff,
// QUEUE_DEPTH each); an arrival to a full queue is dropped and flagged.
// When the server is idle it serves, in order: an overdue takeoff head
// (wait strictly above overdue_limit), the landing head, the takeoff head,
// then stays busy for the configured duration.
// Every req_ word yields exactly one rsp_ word: service kind and wait, queue
// lengths after service, drops, busy flag and saturating counts and sums.
// rsp_valid is registered: it rises in the cycle after accept. Throughput: one
// tick per cycle while req_stall is low; the whole tick (queue cells shift, head
// compare, sums) is combinational, the head-wait subtract and wait-sum add being the long path.
// Stall: rsp_ holds in an output register; while it is full and rsp_stall
// is high, req_stall is raised, otherwise a new tick is taken while the
// previous result is being drained.
// Reset (synchronous): queues empty, server idle, tick and statistics zero,
// registers at defaults (durations 5, overdue limit 120).
// csr_ writes are always ready; configure only while the block is idle.
module two_queue_runway_arbiter_with_aging #(
   parameter int QUEUE_DEPTH = tqra_pkg::QUEUE_DEPTH_DEF,
   parameter int TICK_WIDTH  = tqra_pkg::TICK_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // tick words in
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tqra_pkg::req_word_type req_payload,
   // result words out
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tqra_pkg::rsp_word_type rsp_payload,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int TW = TICK_WIDTH;

   // registers
   logic [15:0] landing_duration_ff, takeoff_duration_ff, overdue_limit_ff;

   // tick state
   logic [TW-1:0] tick_ff;
   logic [15:0]   busy_ff, busy_in;
   logic [31:0]   landings_done_ff, landings_done_in;
   logic [31:0]   takeoffs_done_ff, takeoffs_done_in;
   logic [47:0]   landing_wait_sum_ff, landing_wait_sum_in;
   logic [47:0]   takeoff_wait_sum_ff, takeoff_wait_sum_in;
   logic [47:0]   landing_len_sum_ff, landing_len_sum_in;
   logic [47:0]   takeoff_len_sum_ff, takeoff_len_sum_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   tqra_pkg::rsp_word_type rsp_payload_ff, rsp_payload_in;

   logic accept;

   // queue interface
   logic          l_push, t_push, l_pop, t_pop;
   logic          l_head_v, t_head_v;
   logic [TW-1:0] l_head_d, t_head_d;
   logic [CW-1:0] l_count, t_count;
   logic          l_full, t_full;

   // service decision
   logic          l_ne, t_ne, idle, overdue, serve_t, serve_l;
   logic [TW-1:0] l_wait, t_wait, wait_sel, l_stamp, t_stamp;
   logic [CW-1:0] l_count_next, t_count_next;
   logic [15:0]   busy_load;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         landing_duration_ff <= tqra_pkg::LANDING_DURATION_RST;
         takeoff_duration_ff <= tqra_pkg::TAKEOFF_DURATION_RST;
         overdue_limit_ff    <= tqra_pkg::OVERDUE_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            tqra_pkg::CSR_LANDING_DURATION: landing_duration_ff <= csr_wdata;
            tqra_pkg::CSR_TAKEOFF_DURATION: takeoff_duration_ff <= csr_wdata;
            tqra_pkg::CSR_OVERDUE_LIMIT:    overdue_limit_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // full queues drop the arrival; push happens before service
   assign l_full = (l_count == CW'(QUEUE_DEPTH));
   assign t_full = (t_count == CW'(QUEUE_DEPTH));
   assign l_push = accept && req_payload.landing_arrival && !l_full;
   assign t_push = accept && req_payload.takeoff_arrival && !t_full;

   // head as seen after this tick's push: an empty queue just pushed has
   // the current tick at its head
   assign l_ne    = l_head_v || l_push;
   assign t_ne    = t_head_v || t_push;
   assign l_stamp = l_head_v ? l_head_d : tick_ff;
   assign t_stamp = t_head_v ? t_head_d : tick_ff;
   assign l_wait  = tick_ff - l_stamp;
   assign t_wait  = tick_ff - t_stamp;

   assign idle    = (busy_ff == 16'd0);
   assign overdue = t_ne && (48'(t_wait) > 48'(overdue_limit_ff));
   assign serve_t = idle && (overdue || (!l_ne && t_ne));
   assign serve_l = idle && !serve_t && l_ne;
   assign t_pop   = accept && serve_t;
   assign l_pop   = accept && serve_l;

   assign wait_sel = serve_t ? t_wait : (serve_l ? l_wait : '0);

   tqra_queue #(.DEPTH(QUEUE_DEPTH), .W(TW)) u_landing_q (
      .clock      (clock),
      .reset      (reset),
      .push       (l_push),
      .pop        (l_pop),
      .push_data  (tick_ff),
      .head_valid (l_head_v),
      .head_data  (l_head_d),
      .count      (l_count)
   );

   tqra_queue #(.DEPTH(QUEUE_DEPTH), .W(TW)) u_takeoff_q (
      .clock      (clock),
      .reset      (reset),
      .push       (t_push),
      .pop        (t_pop),
      .push_data  (tick_ff),
      .head_valid (t_head_v),
      .head_data  (t_head_d),
      .count      (t_count)
   );

   // occupancy after push and service
   assign l_count_next = l_count + CW'(l_push) - CW'(serve_l);
   assign t_count_next = t_count + CW'(t_push) - CW'(serve_t);

   always_comb begin
      busy_load = busy_ff;
      if (serve_t) begin
         busy_load = takeoff_duration_ff;
      end else if (serve_l) begin
         busy_load = landing_duration_ff;
      end
      busy_in = (busy_load != 16'd0) ? busy_load - 16'd1 : 16'd0;

      landings_done_in    = serve_l ? tqra_pkg::sat_inc32(landings_done_ff) : landings_done_ff;
      takeoffs_done_in    = serve_t ? tqra_pkg::sat_inc32(takeoffs_done_ff) : takeoffs_done_ff;
      landing_wait_sum_in = serve_l ? tqra_pkg::sat_add48(landing_wait_sum_ff, 48'(wait_sel))
                                    : landing_wait_sum_ff;
      takeoff_wait_sum_in = serve_t ? tqra_pkg::sat_add48(takeoff_wait_sum_ff, 48'(wait_sel))
                                    : takeoff_wait_sum_ff;
      landing_len_sum_in  = tqra_pkg::sat_add48(landing_len_sum_ff, 48'(l_count_next));
      takeoff_len_sum_in  = tqra_pkg::sat_add48(takeoff_len_sum_ff, 48'(t_count_next));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff             <= '0;
         busy_ff             <= '0;
         landings_done_ff    <= '0;
         takeoffs_done_ff    <= '0;
         landing_wait_sum_ff <= '0;
         takeoff_wait_sum_ff <= '0;
         landing_len_sum_ff  <= '0;
         takeoff_len_sum_ff  <= '0;
      end else if (accept) begin
         tick_ff             <= tick_ff + TW'(1);
         busy_ff             <= busy_in;
         landings_done_ff    <= landings_done_in;
         takeoffs_done_ff    <= takeoffs_done_in;
         landing_wait_sum_ff <= landing_wait_sum_in;
         takeoff_wait_sum_ff <= takeoff_wait_sum_in;
         landing_len_sum_ff  <= landing_len_sum_in;
         takeoff_len_sum_ff  <= takeoff_len_sum_in;
      end
   end

   // result word
   always_comb begin
      rsp_payload_in.served_kind = tqra_pkg::KIND_NONE;
      if (serve_t) begin
         rsp_payload_in.served_kind = overdue ? tqra_pkg::KIND_OVERDUE : tqra_pkg::KIND_TAKEOFF;
      end else if (serve_l) begin
         rsp_payload_in.served_kind = tqra_pkg::KIND_LANDING;
      end
      // waits wider than the port clip to all ones
      rsp_payload_in.served_wait       = (64'(wait_sel) > 64'(tqra_pkg::MAX32))
                                         ? tqra_pkg::MAX32 : 32'(wait_sel);
      rsp_payload_in.landing_queue_len = 7'(l_count_next);
      rsp_payload_in.takeoff_queue_len = 7'(t_count_next);
      rsp_payload_in.drop_flags        = {req_payload.landing_arrival && l_full,
                                          req_payload.takeoff_arrival && t_full};
      rsp_payload_in.server_busy       = (busy_in != 16'd0);
      rsp_payload_in.landings_done     = landings_done_in;
      rsp_payload_in.takeoffs_done     = takeoffs_done_in;
      rsp_payload_in.landing_wait_sum  = landing_wait_sum_in;
      rsp_payload_in.takeoff_wait_sum  = takeoff_wait_sum_in;
      rsp_payload_in.landing_len_sum   = landing_len_sum_in;
      rsp_payload_in.takeoff_len_sum   = takeoff_len_sum_in;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### design/tqra_cell.sv
// One stamp cell of the shifting queue: holds a stamp and its valid bit.
module tqra_cell #(
   parameter int W = tqra_pkg::TICK_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tqra_pkg::cell_ctrl_type ctrl,
   input  logic [W-1:0]           push_data,
   input  logic                   up_valid,   // cell further from the head
   input  logic [W-1:0]           up_data,
   input  logic                   down_valid, // cell nearer the head (1 at the head)
   output logic                   valid,
   output logic [W-1:0]           data
);

   logic         valid_ff, valid_in;
   logic [W-1:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.pop) begin
         // shift towards the head; the last occupied cell takes the new word
         if (up_valid) begin
            valid_in = 1'b1;
            data_in  = up_data;
         end else if (ctrl.push && valid_ff) begin
            valid_in = 1'b1;
            data_in  = push_data;
         end else begin
            valid_in = 1'b0;
         end
      end else if (!valid_ff && down_valid && ctrl.push) begin
         // first free cell takes the new word
         valid_in = 1'b1;
         data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

### design/tqra_queue.sv
// Stamp queue built as a chain of cells, head at cell 0, with occupancy count.
module tqra_queue #(
   parameter int DEPTH = tqra_pkg::QUEUE_DEPTH_DEF,
   parameter int W     = tqra_pkg::TICK_WIDTH_DEF,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,      // already qualified against full
   input  logic          pop,
   input  logic [W-1:0]  push_data,
   output logic          head_valid,
   output logic [W-1:0]  head_data,
   output logic [CW-1:0] count
);

   tqra_pkg::cell_ctrl_type ctrl;
   logic         cell_valid [DEPTH];
   logic [W-1:0] cell_data  [DEPTH];
   logic [CW-1:0] count_ff, count_in;

   assign ctrl.push = push;
   assign ctrl.pop  = pop;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic         up_v, dn_v;
      logic [W-1:0] up_d;
      if (i == DEPTH - 1) begin : g_last
         assign up_v = 1'b0;
         assign up_d = '0;
      end else begin : g_mid
         assign up_v = cell_valid[i+1];
         assign up_d = cell_data[i+1];
      end
      if (i == 0) begin : g_head
         assign dn_v = 1'b1;
      end else begin : g_body
         assign dn_v = cell_valid[i-1];
      end
      tqra_cell #(.W(W)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .push_data  (push_data),
         .up_valid   (up_v),
         .up_data    (up_d),
         .down_valid (dn_v),
         .valid      (cell_valid[i]),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head_valid = cell_valid[0];
   assign head_data  = cell_data[0];
   assign count      = count_ff;

endmodule

### bench/runway_checker.sv
// Scoreboard for the runway arbiter: predicts each tick and checks every result word.
`timescale 1ns / 100ps

module runway_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  tqra_pkg::req_word_type req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  tqra_pkg::rsp_word_type rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   output int                     fail_count,
   output int                     pending
);
   import tqra_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEF;

   // own copy of the arbiter state
   logic [31:0] land_stamp [DEPTH];
   logic [31:0] take_stamp [DEPTH];
   int          land_head, land_cnt, take_head, take_cnt;
   logic [15:0] land_ticks, take_ticks, overdue_ticks;
   logic [15:0] busy_left;
   logic [31:0] tick_count;
   logic [31:0] landings, takeoffs;
   logic [47:0] land_wait_total, take_wait_total, land_len_total, take_len_total;

   rsp_word_type due_results [$];

   assign pending = due_results.size();

   initial fail_count = 0;

   function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
      return (a > MAX48 - b) ? MAX48 : a + b;
   endfunction

   // one tick of the arbiter: queue arrivals, serve at most one, update statistics
   task automatic runway_tick(input req_word_type w, output rsp_word_type r);
      logic [1:0]  kind;
      logic [1:0]  drops;
      logic [31:0] waited;
      logic        overdue;
      kind    = KIND_NONE;
      drops   = 2'b00;
      waited  = '0;
      overdue = 1'b0;
      if (w.takeoff_arrival) begin
         if (take_cnt == DEPTH) drops[0] = 1'b1;
         else begin
            take_stamp[(take_head + take_cnt) % DEPTH] = tick_count;
            take_cnt++;
         end
      end
      if (w.landing_arrival) begin
         if (land_cnt == DEPTH) drops[1] = 1'b1;
         else begin
            land_stamp[(land_head + land_cnt) % DEPTH] = tick_count;
            land_cnt++;
         end
      end
      if (busy_left == '0) begin
         if (take_cnt != 0) begin
            waited  = tick_count - take_stamp[take_head];
            overdue = waited > {16'd0, overdue_ticks};
         end
         if (overdue || (land_cnt == 0 && take_cnt != 0)) begin
            kind            = overdue ? KIND_OVERDUE : KIND_TAKEOFF;
            take_head       = (take_head + 1) % DEPTH;
            take_cnt--;
            if (takeoffs != MAX32) takeoffs++;
            take_wait_total = add_sat48(take_wait_total, {16'd0, waited});
            busy_left       = take_ticks;
         end else if (land_cnt != 0) begin
            kind            = KIND_LANDING;
            waited          = tick_count - land_stamp[land_head];
            land_head       = (land_head + 1) % DEPTH;
            land_cnt--;
            if (landings != MAX32) landings++;
            land_wait_total = add_sat48(land_wait_total, {16'd0, waited});
            busy_left       = land_ticks;
         end else begin
            waited = '0;
         end
      end
      take_len_total = add_sat48(take_len_total, 48'(take_cnt));
      land_len_total = add_sat48(land_len_total, 48'(land_cnt));
      if (busy_left != '0) busy_left--;

      r.served_kind       = kind;
      r.served_wait       = (kind == KIND_NONE) ? 32'd0 : waited;
      r.landing_queue_len = 7'(land_cnt);
      r.takeoff_queue_len = 7'(take_cnt);
      r.drop_flags        = drops;
      r.server_busy       = (busy_left != '0);
      r.landings_done     = landings;
      r.takeoffs_done     = takeoffs;
      r.landing_wait_sum  = land_wait_total;
      r.takeoff_wait_sum  = take_wait_total;
      r.landing_len_sum   = land_len_total;
      r.takeoff_len_sum   = take_len_total;
      tick_count++;
   endtask

   task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want, got;
      if (reset) begin
         land_head = 0; land_cnt = 0; take_head = 0; take_cnt = 0;
         land_ticks    = LANDING_DURATION_RST;
         take_ticks    = TAKEOFF_DURATION_RST;
         overdue_ticks = OVERDUE_LIMIT_RST;
         busy_left  = '0;
         tick_count = '0;
         landings   = '0;
         takeoffs   = '0;
         land_wait_total = '0; take_wait_total = '0;
         land_len_total  = '0; take_len_total  = '0;
         due_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LANDING_DURATION: land_ticks    = csr_wdata;
               CSR_TAKEOFF_DURATION: take_ticks    = csr_wdata;
               CSR_OVERDUE_LIMIT:    overdue_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            runway_tick(req_payload, want);
            due_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (due_results.size() == 0) begin
               $display("%0t: result word with none expected, expected none, got %h", $time, got);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               check_field("served_kind",       want.served_kind,       got.served_kind);
               check_field("served_wait",       want.served_wait,       got.served_wait);
               check_field("landing_queue_len", want.landing_queue_len, got.landing_queue_len);
               check_field("takeoff_queue_len", want.takeoff_queue_len, got.takeoff_queue_len);
               check_field("drop_flags",        want.drop_flags,        got.drop_flags);
               check_field("server_busy",       want.server_busy,       got.server_busy);
               check_field("landings_done",     want.landings_done,     got.landings_done);
               check_field("takeoffs_done",     want.takeoffs_done,     got.takeoffs_done);
               check_field("landing_wait_sum",  want.landing_wait_sum,  got.landing_wait_sum);
               check_field("takeoff_wait_sum",  want.takeoff_wait_sum,  got.takeoff_wait_sum);
               check_field("landing_len_sum",   want.landing_len_sum,   got.landing_len_sum);
               check_field("takeoff_len_sum",   want.takeoff_len_sum,   got.takeoff_len_sum);
            end
         end
      end
   end

endmodule

### bench/tb_top.sv
// Testbench top for the runway arbiter: clock, reset, stimulus phases and verdict.
`timescale 1ns / 100ps

module tb_top;
   import tqra_pkg::*;

   // csr index that decodes to no register; writes to it must change nothing
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // cycle budget: many times the roughly 1550 ticks sent
   localparam int CYCLE_LIMIT = 200_000;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_payload;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   int fail_count;
   int pending;
   int cycles = 0;

   // chance in a hundred, per cycle, of the sender holding back / the receiver stalling
   int gap_pct   = 0;
   int stall_pct = 0;

   always #10 clock = ~clock;

   two_queue_runway_arbiter_with_aging u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   runway_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Offer one tick word and hold it until taken. Handshake inputs are read at
   // the falling edge, where they are settled for the next rising edge.
   task automatic send_tick(input req_word_type w);
      logic stalled;
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   // csr_valid is left high; the caller drops it once the batch of writes is done
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      logic ready_seen;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do begin
         @(negedge clock);
         ready_seen = csr_ready;
         @(posedge clock);
      end while (!ready_seen);
   endtask

   // stop offering words and wait until every predicted result word is back
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // One stretch of random ticks under one register setting and one idling mode.
   // Arrival odds are per tick, per queue, in percent.
   task automatic run_phase(input bit reprogram, input logic [15:0] land_ticks,
                            input logic [15:0] take_ticks, input logic [15:0] overdue_ticks,
                            input idle_mode_type mode, input int words,
                            input int take_pct, input int land_pct);
      req_word_type w;
      if (reprogram) begin
         write_reg(CSR_LANDING_DURATION, land_ticks);
         write_reg(CSR_TAKEOFF_DURATION, take_ticks);
         write_reg(CSR_OVERDUE_LIMIT, overdue_ticks);
         csr_valid <= 1'b0;
      end
      case (mode)
         IDLE_SENDER:   begin gap_pct = 56; stall_pct = 0;  end
         IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 56; end
         IDLE_BOTH:     begin gap_pct = 35; stall_pct = 35; end
         default:       begin gap_pct = 0;  stall_pct = 0;  end
      endcase
      for (int i = 0; i < words; i++) begin
         w.takeoff_arrival = ($urandom_range(99) < take_pct);
         w.landing_arrival = ($urandom_range(99) < land_pct);
         send_tick(w);
      end
      drain();
   endtask

   // Directed opening under reset defaults, as {takeoff, landing} flags: an empty
   // tick, lone takeoff served at once, landing beating a waiting takeoff, both
   // arriving together, queues building while the server is busy, then draining.
   logic [1:0] opening [22] = '{2'b00, 2'b10, 2'b01, 2'b11, 2'b11, 2'b01, 2'b10, 2'b00,
                                2'b11, 2'b11, 2'b11, 2'b11, 2'b00, 2'b01, 2'b10, 2'b00,
                                2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) send_tick(req_word_type'(opening[i]));
      drain();

      // a write to the unused index must leave the defaults in place
      write_reg(CSR_UNUSED, 16'($urandom));
      csr_valid <= 1'b0;

      // defaults, landing-heavy: takeoffs starve until they age past the limit
      run_phase(1'b0, '0, '0, '0, IDLE_NONE, 225, 30, 70);
      // shortest service, every waiting takeoff counts as overdue
      run_phase(1'b1, 16'd1, 16'd1, 16'd0, IDLE_SENDER, 225, 50, 50);
      // zero duration keeps the server idle; aging never fires
      run_phase(1'b1, 16'd0, 16'd0, 16'hFFFF, IDLE_RECEIVER, 225, 60, 60);
      // slow server under heavy load: both queues fill and arrivals drop
      run_phase(1'b1, 16'd20, 16'd20, 16'd10, IDLE_BOTH, 225, 80, 80);
      run_phase(1'b1, 16'd3, 16'd7, 16'($urandom_range(300)), IDLE_NONE, 225, 40, 40);
      run_phase(1'b1, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                16'($urandom_range(50)), IDLE_SENDER, 225,
                $urandom_range(10, 90), $urandom_range(10, 90));
      // largest settings last: after one service the server stays busy for the
      // rest of the run, so the queues fill and drop
      run_phase(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, IDLE_BOTH, 150, 90, 90);

      // wait out the registered result path so that anything stray shows up
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### two_queue_runway_arbiter_with_aging.f
design/tqra_pkg.sv
design/tqra_cell.sv
design/tqra_queue.sv
design/two_queue_runway_arbiter_with_aging.sv
bench/runway_checker.sv
bench/tb_top.sv
